/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* hw/rtl/ppei_pkg.sv */
// ----------------------------------------------------------------------------
// ppei_pkg
// Types, constants, the easing table and helpers for the eased interpolator.
// ----------------------------------------------------------------------------
package ppei_pkg;

    // Easing table resolution: the table has 2^EASE_TABLE_BITS + 1 entries.
    localparam int EASE_TABLE_BITS = 10;
    localparam int EASE_N          = 1 << EASE_TABLE_BITS;
    localparam int EASE_AW         = $clog2(EASE_N + 1);
    localparam int EASE_W          = 17;

    localparam int PROG_W    = 17;
    localparam int IDX_SHIFT = 16 - EASE_TABLE_BITS;
    localparam int IDX_ROUND = 1 << (15 - EASE_TABLE_BITS);
    localparam logic [PROG_W-1:0] ONE_Q16 = 17'h10000;

    // Step in Q8.16 after rounding rate * time; 24 bits cover the full range.
    localparam int STEP_W = 24;
    localparam int PSUM_W = STEP_W + 2;

    // Shared shift-add multiplier: signed 33-bit by unsigned 17-bit.
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int MUL_CW    = $clog2(MUL_STEPS);

    // Motion test: a step component of 1024 or more already exceeds the
    // threshold on its own, so only the ten low bits ever need squaring.
    localparam int SMALL_W = 10;
    localparam int MAG_W   = 2 * SMALL_W + 2;
    localparam logic [MAG_W-1:0] MOVE_THRESH = 22'd429496;

    localparam int AXES = 3;
    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [23:0]        RATE_RESET    = 24'd32768;
    localparam logic signed [31:0] START_Y_RESET = 32'sd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_RATE    = 3'd1,
        CFG_START_X = 3'd2,
        CFG_START_Y = 3'd3,
        CFG_START_Z = 3'd4,
        CFG_END_X   = 3'd5,
        CFG_END_Y   = 3'd6,
        CFG_END_Z   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef logic [EASE_W-1:0] ease_rom_t [0:EASE_N];

    localparam logic [63:0] PI_Q28  = 64'd843314857;
    localparam logic [63:0] ONE_Q28 = 64'd268435456;
    localparam logic [63:0] TAYLOR_DIV [0:9] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    // Taylor cosine in Q28 up to the x^20 term, evaluated at elaboration only.
    function automatic logic signed [63:0] cos_q28(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x + (64'd1 << 27)) >> 28;
        term = ONE_Q28;
        sum  = $signed(ONE_Q28);
        for (int k = 0; k < 10; k++)
        begin
            term = ((term * x2) >> 28) / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return sum;
    endfunction

    // Ease-in-out-sine table, (1 - cos(pi * p)) / 2 in Q1.16.
    function automatic ease_rom_t build_ease_rom();
        ease_rom_t          rom;
        logic [63:0]        x;
        logic signed [63:0] c;
        logic [63:0]        cu;
        for (int i = 0; i <= EASE_N / 2; i++)
        begin
            x = (PI_Q28 * 64'(i) + 64'(EASE_N / 2)) >> EASE_TABLE_BITS;
            c = cos_q28(x);
            if (c < 0)
                c = 0;
            if (c > $signed(ONE_Q28))
                c = $signed(ONE_Q28);
            cu = $unsigned(c);
            rom[i] = EASE_W'((ONE_Q28 - cu + 64'd4096) >> 13);
        end
        for (int i = EASE_N / 2 + 1; i <= EASE_N; i++)
        begin
            rom[i] = ONE_Q16 - rom[EASE_N - i];
        end
        return rom;
    endfunction

    localparam ease_rom_t EASE_ROM = build_ease_rom();

    // Clamp a 35-bit signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (!v[34] && (|v[33:31]))
            r = 32'sh7FFF_FFFF;
        else if (v[34] && !(&v[33:31]))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hw/rtl/ppei_ser_mul.sv */
// ----------------------------------------------------------------------------
// ppei_ser_mul
// Shift-add multiplier, one multiplier bit per cycle, signed by unsigned.
// ----------------------------------------------------------------------------
module ppei_ser_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [ppei_pkg::MUL_A_W-1:0]    mcand,
    input  logic        [ppei_pkg::MUL_B_W-1:0]    mplier,
    output ppei_pkg::mul_stat_t                    stat,
    output logic signed [ppei_pkg::MUL_P_W-1:0]    prod
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [ppei_pkg::MUL_CW-1:0]         cnt_reg;
    logic signed [ppei_pkg::MUL_P_W-1:0] acc_reg;
    logic signed [ppei_pkg::MUL_P_W-1:0] shift_reg;
    logic [ppei_pkg::MUL_B_W-1:0]        bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ppei_pkg::MUL_CW'(ppei_pkg::MUL_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The multiplicand walks left while the multiplier bits walk right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            shift_reg <= ppei_pkg::MUL_P_W'(mcand);
            bits_reg  <= mplier;
        end
        else if (busy_reg)
        begin
            if (bits_reg[0])
                acc_reg <= acc_reg + shift_reg;
            shift_reg <= shift_reg << 1;
            bits_reg  <= bits_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

/* hw/rtl/ping_pong_eased_position_interpolator.sv */
// ----------------------------------------------------------------------------
// ping_pong_eased_position_interpolator
// Ping-pong progress with ease-in-out-sine easing and linear interpolation.
// ----------------------------------------------------------------------------
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_stall     elapsed_time
//   out      source     out_valid / out_stall   pos_*, moving, trail_*, heading_back
//   cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An enabled tick makes four passes through the shared shift-add multiplier, one
// for rate times elapsed time and one per axis. In order: accept, the rate pass,
// progress update, table read, then per axis a pass start, multiply, position and
// square, and finally the output load. A disabled tick is taken and dropped.
// Reset loads the register defaults and clears progress, direction and the last
// position. A stalled output holds the block in its final state only while the
// previous beat still waits; otherwise a new tick is taken behind that beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ping_pong_eased_position_interpolator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic        [15:0]                     elapsed_time,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [31:0]                     pos_x,
    output logic signed [31:0]                     pos_y,
    output logic signed [31:0]                     pos_z,
    output logic                                   moving,
    output logic signed [31:0]                     trail_x,
    output logic signed [31:0]                     trail_y,
    output logic signed [31:0]                     trail_z,
    output logic                                   heading_back,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [ppei_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [31:0]                     cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_STEP     = 9'b000000010,
        S_PROG     = 9'b000000100,
        S_ROM      = 9'b000001000,
        S_AX_START = 9'b000010000,
        S_AX_MUL   = 9'b000100000,
        S_AX_POS   = 9'b001000000,
        S_AX_SQ    = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic                     enable_reg;
    logic [23:0]              rate_reg;
    logic signed [31:0]       start_reg [ppei_pkg::AXES];
    logic signed [31:0]       end_reg   [ppei_pkg::AXES];

    // Motion state.
    logic [ppei_pkg::PROG_W-1:0] progress_reg;
    logic                        reversing_reg;
    logic signed [31:0]          last_reg  [ppei_pkg::AXES];
    logic signed [31:0]          trail_reg [ppei_pkg::AXES];
    logic [1:0]                  axis_reg;
    logic [ppei_pkg::EASE_W-1:0] ease_data_reg;
    logic                        moving_big_reg;
    logic [ppei_pkg::SMALL_W-1:0] small_reg;
    logic [ppei_pkg::MAG_W-1:0]  mag2_reg;

    // Output beat.
    logic                        out_valid_reg;
    logic signed [31:0]          out_pos_reg   [ppei_pkg::AXES];
    logic signed [31:0]          out_trail_reg [ppei_pkg::AXES];
    logic                        out_moving_reg;
    logic                        out_heading_reg;

    logic in_accept;
    logic out_free;
    logic out_load;

    // Multiplier hookup.
    logic                                  mul_start;
    logic signed [ppei_pkg::MUL_A_W-1:0]   mul_mcand;
    logic        [ppei_pkg::MUL_B_W-1:0]   mul_mplier;
    ppei_pkg::mul_stat_t                   mul_stat;
    logic signed [ppei_pkg::MUL_P_W-1:0]   mul_prod;

    // Progress update.
    logic [ppei_pkg::MUL_P_W-1:0]       step_sum;
    logic [ppei_pkg::STEP_W-1:0]        step;
    logic signed [ppei_pkg::PSUM_W-1:0] p_sum;
    logic                               p_hit_one;
    logic                               p_hit_zero;

    // Table index.
    logic [ppei_pkg::PROG_W:0]                      idx_sum;
    logic [ppei_pkg::PROG_W-ppei_pkg::IDX_SHIFT:0]  idx_raw;
    logic [ppei_pkg::EASE_AW-1:0]                   ease_idx;

    // Per-axis finishing.
    logic signed [ppei_pkg::MUL_A_W-1:0]  axis_delta;
    logic signed [ppei_pkg::MUL_P_W-1:0]  prod_round;
    logic signed [33:0]                   lerp_ofs;
    logic signed [34:0]                   pos_sum;
    logic signed [31:0]                   new_pos;
    logic signed [32:0]                   step_v;
    logic signed [32:0]                   step_neg;
    logic [32:0]                          step_mag;
    logic [2*ppei_pkg::SMALL_W-1:0]       small_sq;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_DONE) && out_free;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            rate_reg     <= ppei_pkg::RATE_RESET;
            start_reg[0] <= '0;
            start_reg[1] <= ppei_pkg::START_Y_RESET;
            start_reg[2] <= '0;
            end_reg[0]   <= '0;
            end_reg[1]   <= '0;
            end_reg[2]   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ppei_pkg::cfg_idx_t'(cfg_index))
                ppei_pkg::CFG_ENABLE:  enable_reg   <= cfg_data[0];
                ppei_pkg::CFG_RATE:    rate_reg     <= cfg_data[23:0];
                ppei_pkg::CFG_START_X: start_reg[0] <= cfg_data;
                ppei_pkg::CFG_START_Y: start_reg[1] <= cfg_data;
                ppei_pkg::CFG_START_Z: start_reg[2] <= cfg_data;
                ppei_pkg::CFG_END_X:   end_reg[0]   <= cfg_data;
                ppei_pkg::CFG_END_Y:   end_reg[1]   <= cfg_data;
                ppei_pkg::CFG_END_Z:   end_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && enable_reg)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (mul_stat.done)
                    state_next = S_PROG;
            end
            S_PROG:     state_next = S_ROM;
            S_ROM:      state_next = S_AX_START;
            S_AX_START: state_next = S_AX_MUL;
            S_AX_MUL:
            begin
                if (mul_stat.done)
                    state_next = S_AX_POS;
            end
            S_AX_POS:   state_next = S_AX_SQ;
            S_AX_SQ:
            begin
                if (axis_reg == ppei_pkg::LAST_AXIS)
                    state_next = S_DONE;
                else
                    state_next = S_AX_START;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------- multiplier operands ----------------
    assign axis_delta = {end_reg[axis_reg][31], end_reg[axis_reg]}
                      - {start_reg[axis_reg][31], start_reg[axis_reg]};

    assign mul_start  = (in_accept && enable_reg) || (state_reg == S_AX_START);
    assign mul_mcand  = (state_reg == S_IDLE)
                      ? $signed({{(ppei_pkg::MUL_A_W - 24){1'b0}}, rate_reg})
                      : axis_delta;
    assign mul_mplier = (state_reg == S_IDLE) ? {1'b0, elapsed_time} : ease_data_reg;

    ppei_ser_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .stat   (mul_stat),
        .prod   (mul_prod)
    );

    // ---------------- progress and table index ----------------
    assign step_sum = $unsigned(mul_prod) + ppei_pkg::MUL_P_W'(32768);
    assign step     = step_sum[16 +: ppei_pkg::STEP_W];

    always_comb
    begin
        if (reversing_reg)
            p_sum = $signed(ppei_pkg::PSUM_W'(progress_reg)) - $signed(ppei_pkg::PSUM_W'(step));
        else
            p_sum = $signed(ppei_pkg::PSUM_W'(progress_reg)) + $signed(ppei_pkg::PSUM_W'(step));
    end

    assign p_hit_one  = (p_sum >= $signed(ppei_pkg::PSUM_W'(ppei_pkg::ONE_Q16)));
    assign p_hit_zero = p_sum[ppei_pkg::PSUM_W-1] || (p_sum == '0);

    assign idx_sum = {1'b0, progress_reg} + (ppei_pkg::PROG_W + 1)'(ppei_pkg::IDX_ROUND);
    assign idx_raw = idx_sum[ppei_pkg::PROG_W:ppei_pkg::IDX_SHIFT];
    assign ease_idx =
        (idx_raw > (ppei_pkg::PROG_W + 1 - ppei_pkg::IDX_SHIFT)'(ppei_pkg::EASE_N))
        ? ppei_pkg::EASE_AW'(ppei_pkg::EASE_N)
        : idx_raw[ppei_pkg::EASE_AW-1:0];

    // Easing table ROM with a registered read port.
    always_ff @(posedge clk)
    begin
        ease_data_reg <= ppei_pkg::EASE_ROM[ease_idx];
    end

    // ---------------- per-axis finishing ----------------
    assign prod_round = mul_prod + ppei_pkg::MUL_P_W'(32768);
    assign lerp_ofs   = prod_round[ppei_pkg::MUL_P_W-1:16];
    assign pos_sum    = {{3{start_reg[axis_reg][31]}}, start_reg[axis_reg]}
                      + {lerp_ofs[33], lerp_ofs};
    assign new_pos    = ppei_pkg::sat32(pos_sum);
    assign step_v     = {new_pos[31], new_pos} - {last_reg[axis_reg][31], last_reg[axis_reg]};
    assign step_neg   = {last_reg[axis_reg][31], last_reg[axis_reg]} - {new_pos[31], new_pos};
    assign step_mag   = step_v[32] ? $unsigned(step_neg) : $unsigned(step_v);
    assign small_sq   = small_reg * small_reg;

    // ---------------- control and motion state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            progress_reg  <= '0;
            reversing_reg <= 1'b0;
            last_reg[0]   <= '0;
            last_reg[1]   <= '0;
            last_reg[2]   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_PROG)
            begin
                if (p_hit_one)
                begin
                    progress_reg  <= ppei_pkg::ONE_Q16;
                    reversing_reg <= 1'b1;
                end
                else if (p_hit_zero)
                begin
                    progress_reg  <= '0;
                    reversing_reg <= 1'b0;
                end
                else
                begin
                    progress_reg <= p_sum[ppei_pkg::PROG_W-1:0];
                end
            end

            if (state_reg == S_STEP)
                axis_reg <= '0;
            else if ((state_reg == S_AX_SQ) && (axis_reg != ppei_pkg::LAST_AXIS))
                axis_reg <= axis_reg + 1'b1;

            if (state_reg == S_AX_POS)
                last_reg[axis_reg] <= new_pos;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- working and output payload ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STEP)
        begin
            moving_big_reg <= 1'b0;
            mag2_reg       <= '0;
        end

        if (state_reg == S_AX_POS)
        begin
            trail_reg[axis_reg] <= ppei_pkg::sat32({{2{step_neg[32]}}, step_neg});
            small_reg           <= step_mag[ppei_pkg::SMALL_W-1:0];
            if (|step_mag[32:ppei_pkg::SMALL_W])
                moving_big_reg <= 1'b1;
        end

        if (state_reg == S_AX_SQ)
            mag2_reg <= mag2_reg + ppei_pkg::MAG_W'(small_sq);

        if (out_load)
        begin
            for (int a = 0; a < ppei_pkg::AXES; a++)
            begin
                out_pos_reg[a]   <= last_reg[a];
                out_trail_reg[a] <= trail_reg[a];
            end
            out_moving_reg  <= moving_big_reg || (mag2_reg > ppei_pkg::MOVE_THRESH);
            out_heading_reg <= reversing_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = out_pos_reg[0];
    assign pos_y        = out_pos_reg[1];
    assign pos_z        = out_pos_reg[2];
    assign trail_x      = out_trail_reg[0];
    assign trail_y      = out_trail_reg[1];
    assign trail_z      = out_trail_reg[2];
    assign moving       = out_moving_reg;
    assign heading_back = out_heading_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPLY(a_mul_done_when_waiting, clk, rst_n, mul_stat.done,
        (state_reg == S_STEP) || (state_reg == S_AX_MUL))
    `ASSERT_NEXT(a_tick_starts_mul, clk, rst_n, in_accept && enable_reg,
        mul_stat.busy && (state_reg == S_STEP))
    `ASSERT_IMPLY(a_zero_heads_forward, clk, rst_n, progress_reg == '0, !reversing_reg)
    `ASSERT_IMPLY(a_one_heads_back, clk, rst_n, progress_reg == ppei_pkg::ONE_Q16, reversing_reg)

endmodule
